// ----- rtl/triangle_tangent_defines.svh -----
// Assertion helpers for the file that checks its own logic (triangle_tangent.sv).
`ifndef TRIANGLE_TANGENT_DEFINES_SVH
`define TRIANGLE_TANGENT_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define TT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define TT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tt_pkg.sv -----
package tt_pkg;

  localparam int NORM_BITS  = 30;
  localparam int OUT_W      = 18;
  localparam int MUL_CHUNK  = 16;
  localparam int CNT_W      = 6;
  localparam int SQ_W       = 2 * NORM_BITS + 2;
  localparam int SQRT_W     = 2 * NORM_BITS + 4;
  localparam int SQRT_STEPS = NORM_BITS + 2;
  localparam int LEN_W      = NORM_BITS + 2;
  localparam int SQ_TERMS   = 4;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_HOLD0,
    DP_HOLD1,
    DP_DIFF,
    DP_MUL_START,
    DP_MUL_STEP,
    DP_MUL_WB,
    DP_DEGEN,
    DP_MAG,
    DP_NORM,
    DP_SQ,
    DP_SQRT_INIT,
    DP_SQRT_STEP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_WB,
    DP_PUBLISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic norm_zero;
    logic norm_done;
  } dp_status_t;

endpackage

// ----- rtl/tt_datapath.sv -----
module tt_datapath #(
  parameter int COORD_WIDTH   = 32,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  tt_pkg::dp_cmd_t                 cmd_i,
  output tt_pkg::dp_status_t              status_o,
  input  logic signed [COORD_WIDTH-1:0]   pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]   pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]   pos_z_i,
  input  logic signed [COORD_WIDTH-1:0]   tex_u_i,
  input  logic signed [COORD_WIDTH-1:0]   tex_v_i,
  output logic signed [tt_pkg::OUT_W-1:0] tangent_x_o,
  output logic signed [tt_pkg::OUT_W-1:0] tangent_y_o,
  output logic signed [tt_pkg::OUT_W-1:0] tangent_z_o,
  output logic                            degenerate_o
);

  localparam int C    = COORD_WIDTH;
  localparam int F    = OUT_FRAC_BITS;
  localparam int W    = C + 1;
  localparam int PW   = 2 * W + 1;
  localparam int AW   = 2 * W;
  localparam int MC   = tt_pkg::MUL_CHUNK;
  localparam int NCH  = (W + MC - 1) / MC;
  localparam int BW   = NCH * MC;
  localparam int PADW = BW - W;
  localparam int NB   = tt_pkg::NORM_BITS;
  localparam int DW   = tt_pkg::LEN_W + F;
  localparam int QW   = F + 1;
  localparam int XW   = (F + 2 > tt_pkg::OUT_W) ? F + 2 : tt_pkg::OUT_W;
  localparam int OW   = tt_pkg::OUT_W;
  localparam int SW   = tt_pkg::SQRT_W;

  function automatic logic signed [W-1:0] dif(input logic signed [C-1:0] a,
                                              input logic signed [C-1:0] b);
    dif = {a[C-1], a} - {b[C-1], b};
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    mag = x[W-1] ? -x : x;
  endfunction

  logic signed [C-1:0] pin [3];
  assign pin[0] = pos_x_i;
  assign pin[1] = pos_y_i;
  assign pin[2] = pos_z_i;

  // Held vertices.
  logic signed [C-1:0] hp0_q [3];
  logic signed [C-1:0] hp1_q [3];
  logic signed [C-1:0] hu0_q, hv0_q, hu1_q, hv1_q;

  // Edges.
  logic signed [W-1:0] e1_q [3];
  logic signed [W-1:0] e2_q [3];
  logic signed [W-1:0] du1_q, dv1_q, du2_q, dv2_q;

  // Shared multiplier.
  logic signed [W-1:0] op_a, op_b;
  logic [W-1:0]        ma_q;
  logic [BW-1:0]       mb_q;
  logic                mneg_q;
  logic [AW-1:0]       acc_q;
  logic [W+MC-1:0]     pp;
  logic [PW-1:0]       sprod;

  // Determinant and tangent, then magnitudes.
  logic signed [PW-1:0] tgt_q [4];
  logic [PW-1:0]        nrm_q [3];
  logic                 tneg_q [3];
  logic [PW-1:0]        nor_all;
  logic [NB-1:0]        a_v [3];
  logic [NB-1:0]        a_sel;

  // Sum of squares, root, divide.
  logic [2*NB-1:0]          sq_q;
  logic [tt_pkg::SQ_W-1:0]  s_q;
  logic [SW-1:0]            sr_q, r_q, bit_q, rb;
  logic [tt_pkg::LEN_W-1:0] len;
  logic [DW-1:0]            rem_q, dsor_q;
  logic [QW-1:0]            quo_q, qclamp;
  logic [XW-1:0]            qext, qsig;

  logic [OW-1:0] res_q [3];
  logic          degen_q;
  logic [OW-1:0] out_q [3];
  logic          out_degen_q;

  always_comb begin
    case (cmd_i.sel)
      3'd0:    begin op_a = du1_q; op_b = dv2_q;   end
      3'd1:    begin op_a = dv1_q; op_b = du2_q;   end
      3'd2:    begin op_a = dv2_q; op_b = e1_q[0]; end
      3'd3:    begin op_a = dv1_q; op_b = e2_q[0]; end
      3'd4:    begin op_a = dv2_q; op_b = e1_q[1]; end
      3'd5:    begin op_a = dv1_q; op_b = e2_q[1]; end
      3'd6:    begin op_a = dv2_q; op_b = e1_q[2]; end
      default: begin op_a = dv1_q; op_b = e2_q[2]; end
    endcase
  end

  assign pp    = {{MC{1'b0}}, ma_q} * {{W{1'b0}}, mb_q[BW-1 -: MC]};
  assign sprod = mneg_q ? -{1'b0, acc_q} : {1'b0, acc_q};

  assign nor_all = nrm_q[0] | nrm_q[1] | nrm_q[2];
  for (genvar k = 0; k < 3; k++) begin : g_a
    assign a_v[k] = nrm_q[k][PW-1 -: NB];
  end

  always_comb begin
    case (cmd_i.sel[1:0])
      2'd0:    a_sel = a_v[0];
      2'd1:    a_sel = a_v[1];
      default: a_sel = a_v[2];
    endcase
  end

  assign rb     = r_q + bit_q;
  assign len    = r_q[tt_pkg::LEN_W-1:0];
  assign qclamp = (quo_q > (QW'(1) << F)) ? (QW'(1) << F) : quo_q;
  assign qext   = {{(XW-QW){1'b0}}, qclamp};
  assign qsig   = tneg_q[cmd_i.sel[1:0]] ? -qext : qext;

  assign status_o.det_zero  = (tgt_q[0] == '0);
  assign status_o.norm_zero = (nor_all == '0);
  assign status_o.norm_done = nor_all[PW-1];

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      tt_pkg::DP_HOLD0: begin
        for (int k = 0; k < 3; k++) hp0_q[k] <= pin[k];
        hu0_q <= tex_u_i;
        hv0_q <= tex_v_i;
      end
      tt_pkg::DP_HOLD1: begin
        for (int k = 0; k < 3; k++) hp1_q[k] <= pin[k];
        hu1_q <= tex_u_i;
        hv1_q <= tex_v_i;
      end
      tt_pkg::DP_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          e1_q[k] <= dif(hp1_q[k], hp0_q[k]);
          e2_q[k] <= dif(pin[k], hp0_q[k]);
        end
        du1_q   <= dif(hu1_q, hu0_q);
        dv1_q   <= dif(hv1_q, hv0_q);
        du2_q   <= dif(tex_u_i, hu0_q);
        dv2_q   <= dif(tex_v_i, hv0_q);
        degen_q <= 1'b0;
      end
      tt_pkg::DP_MUL_START: begin
        ma_q   <= mag(op_a);
        mb_q   <= {{PADW{1'b0}}, mag(op_b)};
        mneg_q <= op_a[W-1] ^ op_b[W-1];
        acc_q  <= '0;
      end
      tt_pkg::DP_MUL_STEP: begin
        acc_q <= {acc_q[AW-MC-1:0], {MC{1'b0}}} + {{(W-MC){1'b0}}, pp};
        mb_q  <= mb_q << MC;
      end
      tt_pkg::DP_MUL_WB: begin
        tgt_q[cmd_i.sel[2:1]] <= cmd_i.sel[0] ? tgt_q[cmd_i.sel[2:1]] - sprod : sprod;
      end
      tt_pkg::DP_DEGEN: begin
        for (int k = 0; k < 3; k++) res_q[k] <= '0;
        degen_q <= 1'b1;
      end
      tt_pkg::DP_MAG: begin
        for (int k = 0; k < 3; k++) begin
          nrm_q[k]  <= tgt_q[k+1][PW-1] ? -tgt_q[k+1] : tgt_q[k+1];
          tneg_q[k] <= tgt_q[k+1][PW-1] ^ tgt_q[0][PW-1];
        end
      end
      tt_pkg::DP_NORM: begin
        for (int k = 0; k < 3; k++) begin
          if (nor_all[PW-1 -: 8] == '0) nrm_q[k] <= nrm_q[k] << 8;
          else                          nrm_q[k] <= nrm_q[k] << 1;
        end
      end
      tt_pkg::DP_SQ: begin
        sq_q <= a_sel * a_sel;
        if (cmd_i.sel == '0) s_q <= '0;
        else                 s_q <= s_q + {2'b00, sq_q};
      end
      tt_pkg::DP_SQRT_INIT: begin
        sr_q  <= {{(SW-tt_pkg::SQ_W){1'b0}}, s_q};
        r_q   <= '0;
        bit_q <= SW'(1) << (SW - 2);
      end
      tt_pkg::DP_SQRT_STEP: begin
        if (sr_q >= rb) begin
          sr_q <= sr_q - rb;
          r_q  <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      tt_pkg::DP_DIV_INIT: begin
        rem_q  <= ({{(DW-NB){1'b0}}, a_sel} << F) + {{F{1'b0}}, len >> 1};
        dsor_q <= {{F{1'b0}}, len} << F;
        quo_q  <= '0;
      end
      tt_pkg::DP_DIV_STEP: begin
        if (rem_q >= dsor_q) begin
          rem_q <= rem_q - dsor_q;
          quo_q <= {quo_q[QW-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[QW-2:0], 1'b0};
        end
        dsor_q <= dsor_q >> 1;
      end
      tt_pkg::DP_DIV_WB: begin
        res_q[cmd_i.sel[1:0]] <= qsig[OW-1:0];
      end
      tt_pkg::DP_PUBLISH: begin
        for (int k = 0; k < 3; k++) out_q[k] <= res_q[k];
        out_degen_q <= degen_q;
      end
      default: ;
    endcase
  end

  assign tangent_x_o  = out_q[0];
  assign tangent_y_o  = out_q[1];
  assign tangent_z_o  = out_q[2];
  assign degenerate_o = out_degen_q;

endmodule

// ----- rtl/tt_ctrl.sv -----
module tt_ctrl #(
  parameter int MUL_STEPS = 3,
  parameter int DIV_STEPS = 17
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  tt_pkg::dp_status_t status_i,
  output tt_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_START, S_MUL_RUN, S_MUL_WB, S_DET, S_MAG, S_NORM, S_SQ,
    S_SQRT_INIT, S_SQRT, S_DIV_INIT, S_DIV, S_DIV_WB, S_DONE
  } state_e;

  localparam int CW = tt_pkg::CNT_W;

  state_e              state_q;
  logic [1:0]          slot_q;
  logic [CW-1:0]       cnt_q;
  logic [2:0]          idx_q;
  logic                out_valid_q;
  logic                accept;
  logic                publish;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign publish     = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.op  = tt_pkg::DP_NOP;
    cmd_o.sel = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (slot_q)
            2'd1:    cmd_o.op = tt_pkg::DP_HOLD1;
            2'd2:    cmd_o.op = tt_pkg::DP_DIFF;
            default: cmd_o.op = tt_pkg::DP_HOLD0;
          endcase
        end
      end
      S_MUL_START: cmd_o.op = tt_pkg::DP_MUL_START;
      S_MUL_RUN:   cmd_o.op = tt_pkg::DP_MUL_STEP;
      S_MUL_WB:    cmd_o.op = tt_pkg::DP_MUL_WB;
      S_DET:       cmd_o.op = status_i.det_zero ? tt_pkg::DP_DEGEN : tt_pkg::DP_NOP;
      S_MAG:       cmd_o.op = tt_pkg::DP_MAG;
      S_NORM: begin
        if (status_i.norm_zero)      cmd_o.op = tt_pkg::DP_DEGEN;
        else if (!status_i.norm_done) cmd_o.op = tt_pkg::DP_NORM;
      end
      S_SQ: begin
        cmd_o.op  = tt_pkg::DP_SQ;
        cmd_o.sel = cnt_q[2:0];
      end
      S_SQRT_INIT: cmd_o.op = tt_pkg::DP_SQRT_INIT;
      S_SQRT:      cmd_o.op = tt_pkg::DP_SQRT_STEP;
      S_DIV_INIT:  cmd_o.op = tt_pkg::DP_DIV_INIT;
      S_DIV:       cmd_o.op = tt_pkg::DP_DIV_STEP;
      S_DIV_WB:    cmd_o.op = tt_pkg::DP_DIV_WB;
      S_DONE:      cmd_o.op = publish ? tt_pkg::DP_PUBLISH : tt_pkg::DP_NOP;
      default:     cmd_o.op = tt_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= 2'd0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (publish)                     out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (slot_q)
              2'd1: slot_q <= 2'd2;
              2'd2: begin
                slot_q  <= 2'd0;
                idx_q   <= '0;
                state_q <= S_MUL_START;
              end
              default: slot_q <= 2'd1;
            endcase
          end
        end
        S_MUL_START: begin
          cnt_q   <= '0;
          state_q <= S_MUL_RUN;
        end
        S_MUL_RUN: begin
          if (cnt_q == CW'(MUL_STEPS - 1)) state_q <= S_MUL_WB;
          else                             cnt_q   <= cnt_q + 1'b1;
        end
        S_MUL_WB: begin
          if (idx_q == 3'd1)      state_q <= S_DET;
          else if (idx_q == 3'd7) state_q <= S_MAG;
          else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_MUL_START;
          end
        end
        S_DET: begin
          if (status_i.det_zero) state_q <= S_DONE;
          else begin
            idx_q   <= 3'd2;
            state_q <= S_MUL_START;
          end
        end
        S_MAG: state_q <= S_NORM;
        S_NORM: begin
          if (status_i.norm_zero) state_q <= S_DONE;
          else if (status_i.norm_done) begin
            cnt_q   <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt_q == CW'(tt_pkg::SQ_TERMS - 1)) state_q <= S_SQRT_INIT;
          else                                    cnt_q   <= cnt_q + 1'b1;
        end
        S_SQRT_INIT: begin
          cnt_q   <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (cnt_q == CW'(tt_pkg::SQRT_STEPS - 1)) begin
            idx_q   <= '0;
            state_q <= S_DIV_INIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DIV_INIT: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == CW'(DIV_STEPS - 1)) state_q <= S_DIV_WB;
          else                             cnt_q   <= cnt_q + 1'b1;
        end
        S_DIV_WB: begin
          if (idx_q == 3'd2) state_q <= S_DONE;
          else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_DIV_INIT;
          end
        end
        S_DONE: begin
          if (publish) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/triangle_tangent.sv -----
// The first two vertices of a triangle are only held; the third starts the computation, which
// runs the shared multiplier, the alignment shifts, the square root and the three divides
// (a zero determinant or an all-zero tangent ends it early with a degenerate result).
// Vertices are held off until the result has moved to the output register, so a new
// triangle is taken only once the previous result has been published.
// Reset (rst_ni low, asynchronous) clears the vertex slot and the output valid.
`include "triangle_tangent_defines.svh"

module triangle_tangent #(
  parameter int COORD_WIDTH   = 32,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]   pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]   pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]   pos_z_i,
  input  logic signed [COORD_WIDTH-1:0]   tex_u_i,
  input  logic signed [COORD_WIDTH-1:0]   tex_v_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [tt_pkg::OUT_W-1:0] tangent_x_o,
  output logic signed [tt_pkg::OUT_W-1:0] tangent_y_o,
  output logic signed [tt_pkg::OUT_W-1:0] tangent_z_o,
  output logic                            degenerate_o
);

  // The multiplier takes one 16-bit slice of the second operand per cycle.
  localparam int MUL_STEPS =
    (COORD_WIDTH + 1 + tt_pkg::MUL_CHUNK - 1) / tt_pkg::MUL_CHUNK;
  // One quotient bit per cycle; the quotient never exceeds one in Q(OUT_FRAC_BITS).
  localparam int DIV_STEPS = OUT_FRAC_BITS + 1;

  tt_pkg::dp_cmd_t    cmd;
  tt_pkg::dp_status_t status;

  // The controller sequences the edge products (determinant first, so a
  // zero determinant can end the triangle early), the leading-zero alignment,
  // the sum of squares, the square root and one divide per component. Results
  // land in a staging set and move to the output register only once the previous
  // beat has been taken, and vertex beats are held off while a result waits.
  tt_ctrl #(
    .MUL_STEPS (MUL_STEPS),
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tt_datapath #(
    .COORD_WIDTH   (COORD_WIDTH),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .tex_u_i      (tex_u_i),
    .tex_v_i      (tex_v_i),
    .tangent_x_o  (tangent_x_o),
    .tangent_y_o  (tangent_y_o),
    .tangent_z_o  (tangent_z_o),
    .degenerate_o (degenerate_o)
  );

  // A degenerate beat always carries a zero tangent.
  `TT_ASSERT_NOW(a_degen_zero, clk_i, rst_ni, out_valid_o && degenerate_o, tangent_x_o == '0 && tangent_y_o == '0 && tangent_z_o == '0, "degenerate result with nonzero tangent")

  // A new result is only published at the end of a computation, while vertices are held off.
  `TT_ASSERT_NOW(a_publish_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result appeared without a computation")

endmodule
